>>> hw/rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define EQC_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define EQC_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> hw/rtl/eqc_pkg.sv
// ----------------------------------------------------------------------------
// eqc_pkg
// Types, codes and defaults for the EEPROM write queue controller.
// ----------------------------------------------------------------------------
package eqc_pkg;

  localparam int QUEUE_DEPTH_DEF  = 16;
  localparam int SECTOR_COUNT_DEF = 1024;

  localparam int CFG_DATA_W = 12;
  localparam int CFG_IDX_W  = 2;

  localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_START = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_END   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_MIN_BATTERY  = 2'd2;

  localparam logic [11:0] WINDOW_START_RST = 12'd2048;
  localparam logic [11:0] WINDOW_END_RST   = 12'd4079;
  localparam logic [9:0]  MIN_BATTERY_RST  = 10'd204;

  localparam logic [1:0] OP_READ  = 2'd0;
  localparam logic [1:0] OP_WRITE = 2'd1;
  localparam logic [1:0] OP_TICK  = 2'd2;

  localparam logic [1:0] SIZE_BYTE = 2'd0;
  localparam logic [1:0] SIZE_HALF = 2'd1;

  localparam logic [1:0] STAT_OK      = 2'd0;
  localparam logic [1:0] STAT_RANGE   = 2'd1;
  localparam logic [1:0] STAT_BUSY    = 2'd2;
  localparam logic [1:0] STAT_BATTERY = 2'd3;

  localparam logic [1:0] CMD_NONE   = 2'd0;
  localparam logic [1:0] CMD_WORD   = 2'd1;
  localparam logic [1:0] CMD_SECTOR = 2'd2;

  localparam logic [1:0] PATH_DIRECT = 2'd0;
  localparam logic [1:0] PATH_READ   = 2'd1;
  localparam logic [1:0] PATH_POP    = 2'd2;

  typedef struct packed {
    logic        half;
    logic [11:0] addr;
    logic [31:0] data;
  } q_entry_t;

  typedef struct packed {
    logic capture;
    logic clr_en;
    logic eval;
    logic qread;
    logic sread;
    logic fin;
  } ctl_cmd_t;

  typedef struct packed {
    logic [1:0] path;
    logic       clr_last;
  } dp_stat_t;

endpackage

>>> hw/rtl/eqc_ram.sv
// ----------------------------------------------------------------------------
// eqc_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module eqc_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

>>> hw/rtl/eqc_ctrl.sv
// ----------------------------------------------------------------------------
// eqc_ctrl
// Sequencer: clearing pass, item capture, evaluation, memory steps, output.
// ----------------------------------------------------------------------------
module eqc_ctrl import eqc_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     in_valid,
  output logic     in_stall,
  output logic     out_valid,
  input  logic     out_stall,
  input  dp_stat_t stat,
  output ctl_cmd_t cmd
);

  localparam logic [2:0] S_CLEAR = 3'd0;
  localparam logic [2:0] S_IDLE  = 3'd1;
  localparam logic [2:0] S_EVAL  = 3'd2;
  localparam logic [2:0] S_QREAD = 3'd3;
  localparam logic [2:0] S_SREAD = 3'd4;
  localparam logic [2:0] S_FIN   = 3'd5;

  logic [2:0] state, state_next;
  logic       out_valid_next;
  logic       out_free;

  assign out_free = !out_valid || !out_stall;
  assign in_stall = (state != S_IDLE);

  always_comb begin
    state_next = state;
    cmd        = '0;
    unique case (state)
      S_CLEAR: begin
        cmd.clr_en = 1'b1;
        if (stat.clr_last) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_next  = S_EVAL;
        end
      end
      S_EVAL: begin
        cmd.eval = 1'b1;
        unique case (stat.path)
          PATH_READ: state_next = S_SREAD;
          PATH_POP:  state_next = S_QREAD;
          default:   state_next = S_FIN;
        endcase
      end
      S_QREAD: begin
        cmd.qread  = 1'b1;
        state_next = S_SREAD;
      end
      S_SREAD: begin
        cmd.sread  = 1'b1;
        state_next = S_FIN;
      end
      S_FIN: begin
        if (out_free) begin
          cmd.fin    = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_CLEAR;
    endcase
  end

  assign out_valid_next = cmd.fin ? 1'b1 : (out_valid && out_stall);

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLEAR;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
    end
  end

endmodule

>>> hw/rtl/eqc_datapath.sv
// ----------------------------------------------------------------------------
// eqc_datapath
// Config registers, access checks, queue pointers, queue and sector memories,
// merge logic and output registers.
// ----------------------------------------------------------------------------
module eqc_datapath import eqc_pkg::*; #(
  parameter int QUEUE_DEPTH  = QUEUE_DEPTH_DEF,
  parameter int SECTOR_COUNT = SECTOR_COUNT_DEF,
  localparam int FillW = $clog2(QUEUE_DEPTH + 1)
) (
  input  logic                  clk,
  input  logic                  rst,
  input  ctl_cmd_t              cmd,
  output dp_stat_t              stat,
  input  logic                  cfg_write,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic [1:0]            operation,
  input  logic [1:0]            size_code,
  input  logic [15:0]           address,
  input  logic [31:0]           write_data,
  input  logic [9:0]            battery_level,
  input  logic                  flash_ready,
  output logic [1:0]            status,
  output logic [31:0]           read_data,
  output logic [1:0]            command,
  output logic [11:0]           command_address,
  output logic [31:0]           command_data,
  output logic [FillW-1:0]      queue_count,
  output logic [FillW-1:0]      max_depth
);

  localparam int QW = $clog2(QUEUE_DEPTH);
  localparam int SW = $clog2(SECTOR_COUNT);
  localparam logic [QW-1:0]    QLast   = QW'(QUEUE_DEPTH - 1);
  localparam logic [FillW-1:0] FillMax = FillW'(QUEUE_DEPTH);
  localparam logic [SW-1:0]    SLast   = SW'(SECTOR_COUNT - 1);
  localparam logic [12:0]      SCount  = 13'(SECTOR_COUNT);

  // word index modulo sector count; index is below 1024, count at least 256
  function automatic logic [SW-1:0] word_idx(input logic [11:0] a);
    logic [12:0] v;
    v = {3'b000, a[11:2]};
    for (int i = 0; i < 3; i++) begin
      if (v >= SCount) begin
        v = v - SCount;
      end
    end
    return v[SW-1:0];
  endfunction

  // config
  logic [11:0] win_start, win_end;
  logic [9:0]  min_batt;

  // captured item
  logic [1:0]  op_r, size_r;
  logic [15:0] addr_r;
  logic [31:0] wdata_r;
  logic [9:0]  batt_r;
  logic        ready_r;

  // queue control
  logic [QW-1:0]    head, tail, head_next, tail_next;
  logic [FillW-1:0] fill, high;
  logic [SW-1:0]    clr_cnt;
  logic [SW-1:0]    idx_r;

  // result
  logic [1:0]  status_r, cmd_r;
  logic [31:0] rdata_r, cdata_r;
  logic [11:0] caddr_r;

  // decode
  logic [11:0] rd_addr;
  logic [15:0] wr_addr;
  logic        wr_half, batt_low, rd_oor, wr_oor, busy, full;
  logic        read_ok, write_ok, pop;
  logic [1:0]  eval_status;
  q_entry_t    q_wentry, q_rentry;

  // memory ports
  logic          s_we, s_re;
  logic [SW-1:0] s_waddr, s_raddr;
  logic [31:0]   s_wdata, s_rdata;

  // merge
  logic [31:0] rd_val, merged;
  logic [15:0] cur;
  logic        word_prog;

  assign head_next = (head == QLast) ? '0 : head + 1'b1;
  assign tail_next = (tail == QLast) ? '0 : tail + 1'b1;

  always_comb begin
    unique case (size_r)
      SIZE_BYTE: rd_addr = addr_r[11:0];
      SIZE_HALF: rd_addr = {addr_r[11:1], 1'b0};
      default:   rd_addr = {addr_r[11:2], 2'b00};
    endcase
  end

  assign wr_half  = (size_r == SIZE_HALF);
  assign wr_addr  = wr_half ? {addr_r[15:1], 1'b0} : {addr_r[15:2], 2'b00};
  assign batt_low = (batt_r <= min_batt);
  assign rd_oor   = (rd_addr < win_start) || (rd_addr > win_end);
  assign wr_oor   = (wr_addr < {4'b0000, win_start}) || (wr_addr > {4'b0000, win_end});
  assign busy     = (fill != '0) || !ready_r;
  assign full     = (fill == FillMax);

  always_comb begin
    eval_status = STAT_OK;
    read_ok     = 1'b0;
    write_ok    = 1'b0;
    pop         = 1'b0;
    unique case (op_r)
      OP_READ: begin
        if (batt_low) begin
          eval_status = STAT_BATTERY;
        end else if (rd_oor) begin
          eval_status = STAT_RANGE;
        end else if (busy) begin
          eval_status = STAT_BUSY;
        end else begin
          read_ok = 1'b1;
        end
      end
      OP_WRITE: begin
        if (batt_low) begin
          eval_status = STAT_BATTERY;
        end else if (wr_oor) begin
          eval_status = STAT_RANGE;
        end else if (full) begin
          eval_status = STAT_BUSY;
        end else begin
          write_ok = 1'b1;
        end
      end
      OP_TICK: pop = ready_r && (fill != '0);
      default: ;
    endcase
  end

  always_comb begin
    stat.clr_last = (clr_cnt == SLast);
    if (read_ok) begin
      stat.path = PATH_READ;
    end else if (pop) begin
      stat.path = PATH_POP;
    end else begin
      stat.path = PATH_DIRECT;
    end
  end

  assign q_wentry.half = wr_half;
  assign q_wentry.addr = wr_addr[11:0];
  assign q_wentry.data = wr_half ? {16'h0000, wdata_r[15:0]} : wdata_r;

  eqc_ram #(
    .WIDTH ($bits(q_entry_t)),
    .DEPTH (QUEUE_DEPTH)
  ) u_queue_ram (
    .clk   (clk),
    .we    (cmd.eval && write_ok),
    .waddr (head_next),
    .wdata (q_wentry),
    .re    (cmd.eval && pop),
    .raddr (tail_next),
    .rdata (q_rentry)
  );

  // read value
  always_comb begin
    unique case (size_r)
      SIZE_BYTE: begin
        unique case (rd_addr[1:0])
          2'd0:    rd_val = {24'h0, s_rdata[31:24]};
          2'd1:    rd_val = {24'h0, s_rdata[23:16]};
          2'd2:    rd_val = {24'h0, s_rdata[15:8]};
          default: rd_val = {24'h0, s_rdata[7:0]};
        endcase
      end
      SIZE_HALF: rd_val = rd_addr[1] ? {16'h0, s_rdata[15:0]} : {16'h0, s_rdata[31:16]};
      default:   rd_val = s_rdata;
    endcase
  end

  // tick merge
  assign cur       = q_rentry.addr[1] ? s_rdata[15:0] : s_rdata[31:16];
  assign word_prog = q_rentry.half && (cur == 16'hFFFF);

  always_comb begin
    if (q_rentry.half) begin
      merged = q_rentry.addr[1] ? {s_rdata[31:16], q_rentry.data[15:0]}
                                : {q_rentry.data[15:0], s_rdata[15:0]};
    end else begin
      merged = q_rentry.data;
    end
  end

  assign s_we    = cmd.clr_en || (cmd.sread && (op_r == OP_TICK));
  assign s_waddr = cmd.clr_en ? clr_cnt : idx_r;
  assign s_wdata = cmd.clr_en ? '1 : merged;
  assign s_re    = (cmd.eval && read_ok) || cmd.qread;
  assign s_raddr = cmd.qread ? word_idx(q_rentry.addr) : word_idx(rd_addr);

  eqc_ram #(
    .WIDTH (32),
    .DEPTH (SECTOR_COUNT)
  ) u_sector_ram (
    .clk   (clk),
    .we    (s_we),
    .waddr (s_waddr),
    .wdata (s_wdata),
    .re    (s_re),
    .raddr (s_raddr),
    .rdata (s_rdata)
  );

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      win_start <= WINDOW_START_RST;
      win_end   <= WINDOW_END_RST;
      min_batt  <= MIN_BATTERY_RST;
      head      <= '0;
      tail      <= '0;
      fill      <= '0;
      high      <= '0;
      clr_cnt   <= '0;
    end else begin
      if (cfg_write) begin
        unique case (cfg_index)
          CFG_WINDOW_START: win_start <= cfg_data;
          CFG_WINDOW_END:   win_end   <= cfg_data;
          CFG_MIN_BATTERY:  min_batt  <= cfg_data[9:0];
          default: ;
        endcase
      end
      if (cmd.clr_en) begin
        clr_cnt <= clr_cnt + 1'b1;
      end
      if (cmd.eval && write_ok) begin
        head <= head_next;
        fill <= fill + 1'b1;
        if ((fill + 1'b1) > high) begin
          high <= fill + 1'b1;
        end
      end
      if (cmd.eval && pop) begin
        tail <= tail_next;
        fill <= fill - 1'b1;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      op_r    <= operation;
      size_r  <= size_code;
      addr_r  <= address;
      wdata_r <= write_data;
      batt_r  <= battery_level;
      ready_r <= flash_ready;
    end
    if (cmd.eval) begin
      status_r <= eval_status;
      rdata_r  <= '0;
      cmd_r    <= CMD_NONE;
      caddr_r  <= '0;
      cdata_r  <= '0;
    end
    if (cmd.qread) begin
      idx_r <= word_idx(q_rentry.addr);
    end
    if (cmd.sread) begin
      if (op_r == OP_READ) begin
        rdata_r <= rd_val;
      end else if (word_prog) begin
        cmd_r   <= CMD_WORD;
        caddr_r <= q_rentry.addr;
        cdata_r <= q_rentry.data;
      end else begin
        cmd_r   <= CMD_SECTOR;
        caddr_r <= {q_rentry.addr[11:2], 2'b00};
        cdata_r <= merged;
      end
    end
    if (cmd.fin) begin
      status          <= status_r;
      read_data       <= rdata_r;
      command         <= cmd_r;
      command_address <= caddr_r;
      command_data    <= cdata_r;
      queue_count     <= fill;
      max_depth       <= high;
    end
  end

endmodule

>>> hw/rtl/eeprom_write_queue_controller_unit.sv
// ----------------------------------------------------------------------------
// eeprom_write_queue_controller_unit
// Write-behind EEPROM controller: reads, queued writes, tick-driven programming.
//
//   channel  dir  handshake            payload
//   in       in   in_valid / in_stall  operation, size_code, address,
//                                      write_data, battery_level, flash_ready
//   out      out  out_valid/out_stall  status, read_data, command,
//                                      command_address, command_data,
//                                      queue_count, max_depth
//   cfg      in   cfg_write            cfg_index, cfg_data
//
// One item at a time: writes, rejected accesses and idle ticks go through capture,
// evaluation and output; a good read adds a sector read, a tick that pops adds a
// queue read and a sector read; the registered reads of the queue and sector
// memories set the extra steps. After reset, a clearing pass erases the sector
// memory while in_stall is high. A held result delays the next result load until
// out_stall drops; the next item may be taken meanwhile.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module eeprom_write_queue_controller_unit import eqc_pkg::*; #(
  parameter int QUEUE_DEPTH  = QUEUE_DEPTH_DEF,
  parameter int SECTOR_COUNT = SECTOR_COUNT_DEF,
  localparam int FillW = $clog2(QUEUE_DEPTH + 1)
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_write,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic [1:0]            operation,
  input  logic [1:0]            size_code,
  input  logic [15:0]           address,
  input  logic [31:0]           write_data,
  input  logic [9:0]            battery_level,
  input  logic                  flash_ready,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [1:0]            status,
  output logic [31:0]           read_data,
  output logic [1:0]            command,
  output logic [11:0]           command_address,
  output logic [31:0]           command_data,
  output logic [FillW-1:0]      queue_count,
  output logic [FillW-1:0]      max_depth
);

  ctl_cmd_t ctl_cmd;
  dp_stat_t dp_stat;

  eqc_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .stat      (dp_stat),
    .cmd       (ctl_cmd)
  );

  eqc_datapath #(
    .QUEUE_DEPTH  (QUEUE_DEPTH),
    .SECTOR_COUNT (SECTOR_COUNT)
  ) u_datapath (
    .clk             (clk),
    .rst             (rst),
    .cmd             (ctl_cmd),
    .stat            (dp_stat),
    .cfg_write       (cfg_write),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .operation       (operation),
    .size_code       (size_code),
    .address         (address),
    .write_data      (write_data),
    .battery_level   (battery_level),
    .flash_ready     (flash_ready),
    .status          (status),
    .read_data       (read_data),
    .command         (command),
    .command_address (command_address),
    .command_data    (command_data),
    .queue_count     (queue_count),
    .max_depth       (max_depth)
  );

  `EQC_ASSERT_NEXT(a_capture_then_eval, clk, rst, ctl_cmd.capture, ctl_cmd.eval, "eval must follow capture")
  `EQC_ASSERT_IMP(a_count_le_mark, clk, rst, out_valid, queue_count <= max_depth, "queue count above high mark")
  `EQC_ASSERT_IMP(a_no_cmd_zero, clk, rst, out_valid && command == CMD_NONE, command_address == '0 && command_data == '0, "idle command with payload")
  `EQC_ASSERT_IMP(a_cmd_status_ok, clk, rst, out_valid && command != CMD_NONE, status == STAT_OK, "command with error status")

endmodule
